>>> hw/rtl/krqc_pkg.sv
// Shared types and constants for the key report and quadrature counter.
`timescale 1ns / 1ps

package krqc_pkg;

  localparam int unsigned NumKeys    = 8;
  localparam int unsigned CodeW      = 8;
  localparam int unsigned WordW      = 16;
  localparam int unsigned ReqW       = 3;
  localparam int unsigned MaskW      = NumKeys + 1;
  localparam int unsigned CountOutW  = 8;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = NumKeys * CodeW;

  localparam logic [CfgIdxW-1:0] CfgKeyCodes   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgButtonCode = 2'd1;

  localparam logic [CfgDataW-1:0] KeyCodesReset   = 64'h0B0A_0908_0706_0504;
  localparam logic [CodeW-1:0]    ButtonCodeReset = 8'd12;

  // Word bit that carries each key, keys one to eight.
  localparam logic [3:0] KeyBitPos [NumKeys] = '{
    4'd8, 4'd9, 4'd10, 4'd11, 4'd15, 4'd14, 4'd13, 4'd12
  };

  typedef enum logic [ReqW-1:0] {
    ReqKeyWord = 3'd0,
    ReqButton  = 3'd1,
    ReqLeftA   = 3'd2,
    ReqLeftB   = 3'd3,
    ReqRightA  = 3'd4,
    ReqRightB  = 3'd5
  } req_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [WordW-1:0] key_word;
    logic             button_level;
    logic             left_a;
    logic             left_b;
    logic             right_a;
    logic             right_b;
  } in_item_t;

  typedef struct packed {
    logic                      changed;
    logic [MaskW-1:0]          pressed_mask;
    logic [NumKeys*CodeW-1:0]  report_keys;
    logic [CodeW-1:0]          button_report;
    logic [CountOutW-1:0]      left_count;
    logic [CountOutW-1:0]      right_count;
  } out_item_t;

  typedef struct packed {
    logic word_evt;
    logic button_evt;
  } key_evt_t;

  typedef struct packed {
    logic step;
    logic chan_b;
    logic a;
    logic b;
  } enc_evt_t;

endpackage

>>> hw/rtl/key_report_and_quadrature_counter.sv
// Top level: input register, key and encoder state, result register.
// Each accepted transaction waits in the input register, then updates the state and result registers.
// Throughput: one transaction per cycle while the output is not stalled; the input register feeds the state
// update and the result register in a single pass.
// Reset clears all key and encoder state and restores the register defaults.
`timescale 1ns / 1ps

module key_report_and_quadrature_counter #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  krqc_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output krqc_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [krqc_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [krqc_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [krqc_pkg::CfgDataW-1:0] key_codes_q;
  logic [krqc_pkg::CodeW-1:0]    button_code_q;

  logic                  s1_valid_q;
  krqc_pkg::in_item_t    s1_q;
  logic                  out_valid_q;
  logic                  changed_q, changed_d;
  logic                  move, in_acc;

  krqc_pkg::key_evt_t    key_evt;
  krqc_pkg::enc_evt_t    left_evt, right_evt;

  logic [COUNT_BITS-1:0]          left_cnt, right_cnt;
  logic [krqc_pkg::CountOutW-1:0] left8, right8;

  assign move       = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !move;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_codes_q   <= krqc_pkg::KeyCodesReset;
      button_code_q <= krqc_pkg::ButtonCodeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        krqc_pkg::CfgKeyCodes:   key_codes_q   <= cfg_data_i;
        krqc_pkg::CfgButtonCode: button_code_q <= cfg_data_i[krqc_pkg::CodeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      changed_q   <= 1'b0;
    end else begin
      s1_valid_q  <= in_acc || (s1_valid_q && !move);
      out_valid_q <= move || (out_valid_q && out_stall_i);
      if (move) begin
        changed_q <= changed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
  end

  always_comb begin
    key_evt   = '0;
    left_evt  = '{step: 1'b0, chan_b: 1'b0, a: s1_q.left_a, b: s1_q.left_b};
    right_evt = '{step: 1'b0, chan_b: 1'b0, a: s1_q.right_a, b: s1_q.right_b};
    if (move) begin
      unique case (s1_q.req_type)
        krqc_pkg::ReqKeyWord: key_evt.word_evt   = 1'b1;
        krqc_pkg::ReqButton:  key_evt.button_evt = 1'b1;
        krqc_pkg::ReqLeftA:   left_evt.step      = 1'b1;
        krqc_pkg::ReqLeftB: begin
          left_evt.step   = 1'b1;
          left_evt.chan_b = 1'b1;
        end
        krqc_pkg::ReqRightA:  right_evt.step     = 1'b1;
        krqc_pkg::ReqRightB: begin
          right_evt.step   = 1'b1;
          right_evt.chan_b = 1'b1;
        end
        default: ;
      endcase
    end
  end

  krqc_keys u_keys (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .evt_i           (key_evt),
    .key_word_i      (s1_q.key_word),
    .button_level_i  (s1_q.button_level),
    .key_codes_i     (key_codes_q),
    .button_code_i   (button_code_q),
    .changed_o       (changed_d),
    .pressed_mask_o  (out_data_o.pressed_mask),
    .report_keys_o   (out_data_o.report_keys),
    .button_report_o (out_data_o.button_report)
  );

  krqc_quad #(.CountBits(COUNT_BITS)) u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (left_evt),
    .count_o (left_cnt)
  );

  krqc_quad #(.CountBits(COUNT_BITS)) u_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (right_evt),
    .count_o (right_cnt)
  );

  generate
    if (COUNT_BITS >= krqc_pkg::CountOutW) begin : g_cnt_trunc
      assign left8  = left_cnt[krqc_pkg::CountOutW-1:0];
      assign right8 = right_cnt[krqc_pkg::CountOutW-1:0];
    end else begin : g_cnt_ext
      assign left8  = {{(krqc_pkg::CountOutW-COUNT_BITS){1'b0}}, left_cnt};
      assign right8 = {{(krqc_pkg::CountOutW-COUNT_BITS){1'b0}}, right_cnt};
    end
  endgenerate

  assign out_data_o.changed     = changed_q;
  assign out_data_o.left_count  = left8;
  assign out_data_o.right_count = right8;
  assign out_valid_o            = out_valid_q;

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with empty input register");

  a_hold_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !move |=> ($stable(left_cnt) && $stable(right_cnt)))
    else $error("encoder count moved without a transaction");

  a_changed_only_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && (s1_q.req_type != krqc_pkg::ReqKeyWord)) |=> !changed_q)
    else $error("changed raised by a non key word transaction");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !s1_valid_q) |=> !out_valid_q)
    else $error("result repeated after it was taken");
`endif

endmodule

>>> hw/rtl/krqc_keys.sv
// Key word decode, button handling and report slot storage.
`timescale 1ns / 1ps

module krqc_keys (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  krqc_pkg::key_evt_t                            evt_i,
  input  logic [krqc_pkg::WordW-1:0]                    key_word_i,
  input  logic                                          button_level_i,
  input  logic [krqc_pkg::CfgDataW-1:0]                 key_codes_i,
  input  logic [krqc_pkg::CodeW-1:0]                    button_code_i,
  output logic                                          changed_o,
  output logic [krqc_pkg::MaskW-1:0]                    pressed_mask_o,
  output logic [krqc_pkg::NumKeys*krqc_pkg::CodeW-1:0]  report_keys_o,
  output logic [krqc_pkg::CodeW-1:0]                    button_report_o
);

  logic [krqc_pkg::WordW-1:0] last_word_q;
  logic [krqc_pkg::MaskW-1:0] marks_q, marks_d;
  logic [krqc_pkg::CodeW-1:0] slot_q [krqc_pkg::NumKeys];
  logic [krqc_pkg::CodeW-1:0] slot_d [krqc_pkg::NumKeys];
  logic [krqc_pkg::CodeW-1:0] btn_slot_q, btn_slot_d;
  logic                       word_new;

  assign word_new  = evt_i.word_evt && (key_word_i != last_word_q);
  assign changed_o = word_new;

  always_comb begin
    marks_d    = marks_q;
    btn_slot_d = btn_slot_q;
    for (int i = 0; i < krqc_pkg::NumKeys; i++) begin
      slot_d[i] = slot_q[i];
      if (word_new) begin
        if (key_word_i[krqc_pkg::KeyBitPos[i]]) begin
          marks_d[i+1] = 1'b0;
          slot_d[i]    = '0;
        end else begin
          marks_d[i+1] = 1'b1;
          slot_d[i]    = key_codes_i[i*krqc_pkg::CodeW +: krqc_pkg::CodeW];
        end
      end
    end
    if (evt_i.button_evt) begin
      marks_d[0] = !button_level_i;
      btn_slot_d = button_level_i ? '0 : button_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_word_q <= '0;
      marks_q     <= '0;
      btn_slot_q  <= '0;
      for (int i = 0; i < krqc_pkg::NumKeys; i++) begin
        slot_q[i] <= '0;
      end
    end else begin
      if (word_new) begin
        last_word_q <= key_word_i;
      end
      marks_q    <= marks_d;
      btn_slot_q <= btn_slot_d;
      for (int i = 0; i < krqc_pkg::NumKeys; i++) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < krqc_pkg::NumKeys; i++) begin
      report_keys_o[i*krqc_pkg::CodeW +: krqc_pkg::CodeW] = slot_q[i];
    end
  end

  assign pressed_mask_o  = marks_q;
  assign button_report_o = btn_slot_q;

endmodule

>>> hw/rtl/krqc_quad.sv
// x4 quadrature position counter for one encoder.
`timescale 1ns / 1ps

module krqc_quad #(
  parameter int unsigned CountBits = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  krqc_pkg::enc_evt_t    evt_i,
  output logic [CountBits-1:0]  count_o
);

  logic [CountBits-1:0] count_q, count_d;
  logic                 up;

  // A edge: up when levels differ. B edge: up when levels match.
  assign up = evt_i.chan_b ? (evt_i.a == evt_i.b) : (evt_i.a != evt_i.b);

  always_comb begin
    count_d = count_q;
    if (evt_i.step) begin
      count_d = up ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule
